// ----- rtl/rqps_pkg.sv -----
// shared types, codes and controller/datapath interface structs for the record queue
package rqps_pkg;

	// operation codes carried in the request
	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_POP     = 3'd1;
	localparam logic [2:0] OP_CLEAR   = 3'd2;
	localparam logic [2:0] OP_REVERSE = 3'd3;
	localparam logic [2:0] OP_SORT    = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;

	// response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] rec_id;
		logic [7:0]  rec_age;
		logic [4:0]  sort_count;
		logic [3:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_id;
		logic [7:0]  out_age;
		logic [4:0]  fill;
	} out_item_t;

	// one stored record
	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  age;
	} rec_t;

	// which offset from the head addresses the store
	typedef enum logic [2:0] {
		OFF_ZERO  = 3'd0,
		OFF_I     = 3'd1,
		OFF_J     = 3'd2,
		OFF_BEST  = 3'd3,
		OFF_COUNT = 3'd4,
		OFF_RIDX  = 3'd5
	} off_sel_t;

	// source of the store write data
	typedef enum logic [1:0] {
		WD_IN = 2'd0,
		WD_A  = 2'd1,
		WD_B  = 2'd2
	} wd_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic       latch_in;
		logic       mem_we;
		logic       mem_re;
		off_sel_t   off_sel;
		wd_sel_t    wd_sel;
		logic       set_status;
		logic [1:0] status;
		logic       load_a;
		logic       load_b;
		logic       show_rec;
		logic       init_rev;
		logic       init_sort;
		logic       best_start;
		logic       scan_cmp;
		logic       rev_step;
		logic       sort_next;
		logic       push_commit;
		logic       pop_commit;
		logic       clear;
		logic       res_load;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       empty;
		logic       ridx_ok;
		logic       rev_ok;
		logic       rev_more;
		logic       sort_more;
		logic       scan_more;
		logic       best_moved;
	} dp_stat_t;

endpackage

// ----- rtl/record_queue_partial_sort_core.sv -----
// top level of the bounded record queue with partial selection sort
//
// Request channel req (req_valid/req_ready) carries one operation per transfer:
// push, pop, clear, reverse, sort or read. Each request yields exactly one
// response transfer on rsp (rsp_valid/rsp_ready) with status, the popped or
// read record, and the fill level after the operation.
// Requests are handled one at a time by a sequencer over a single-port record
// store (one write or one registered read per cycle).
// Push, clear, full push, empty pop, out-of-range read, spare codes and a reverse
// of fewer than two records go from dispatch straight to the response; pop and read
// first fetch the record, reverse swaps pair by pair, and sort scans the entries
// after each row and swaps only when the row needs it.
// The next request can be taken in the cycle after the response is loaded.
// The response register holds a result while the receiver stalls; the
// sequencer accepts and processes the next request meanwhile and waits
// before loading its result until the register is free.
// Reset empties the queue (head and count to zero); store contents are not
// cleared and are never read before being written.
module record_queue_partial_sort_core import rqps_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	rqps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// store and datapath
	rqps_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/rqps_datapath.sv -----
// datapath of the record queue: record store, pointers, scan registers and response register
module rqps_datapath import rqps_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  req,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output out_item_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OW = (CW > 5) ? CW : 5;

	rec_t            mem_q [DEPTH];
	rec_t            rd_q;
	rec_t            rec_a_q;
	rec_t            rec_b_q;
	in_item_t        req_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [OW-1:0]   i_q;
	logic [OW-1:0]   j_q;
	logic [OW-1:0]   best_q;
	logic [OW-1:0]   n_q;
	logic [1:0]      status_q;
	logic            show_q;
	out_item_t       rsp_q;

	logic [OW-1:0]   cnt_w;
	logic [OW-1:0]   ridx_w;
	logic [OW-1:0]   sc_w;
	logic [OW-1:0]   off;
	logic [OW:0]     slot_sum;
	logic [OW:0]     slot_wrap;
	logic [AW-1:0]   slot;
	logic [AW-1:0]   head_next;
	rec_t            wdata;

	assign cnt_w  = OW'(count_q);
	assign ridx_w = OW'(req_q.read_index);
	assign sc_w   = OW'(req_q.sort_count);

	// offset select and circular slot of head plus offset
	always_comb begin
		case (cmd.off_sel)
			OFF_I:     off = i_q;
			OFF_J:     off = j_q;
			OFF_BEST:  off = best_q;
			OFF_COUNT: off = cnt_w;
			OFF_RIDX:  off = ridx_w;
			default:   off = '0;
		endcase
		slot_sum  = (OW+1)'(head_q) + (OW+1)'(off);
		slot_wrap = (slot_sum >= (OW+1)'(DEPTH)) ? slot_sum - (OW+1)'(DEPTH) : slot_sum;
		slot      = slot_wrap[AW-1:0];
	end

	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// write data select
	always_comb begin
		case (cmd.wd_sel)
			WD_A:    wdata = rec_a_q;
			WD_B:    wdata = rec_b_q;
			default: wdata = '{id: req_q.rec_id, age: req_q.rec_age};
		endcase
	end

	// record store, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[slot] <= wdata;
		end
		if (cmd.mem_re) begin
			rd_q <= mem_q[slot];
		end
	end

	// head pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.push_commit) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop_commit) begin
			head_q  <= head_next;
			count_q <= count_q - CW'(1);
		end
	end

	// request capture, status and record holding registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			req_q    <= req;
			status_q <= ST_OK;
			show_q   <= 1'b0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.show_rec) begin
			show_q <= 1'b1;
		end
		if (cmd.load_a) begin
			rec_a_q <= rd_q;
		end
		if (cmd.load_b) begin
			rec_b_q <= rd_q;
		end else if (cmd.scan_cmp && (rd_q.age > rec_b_q.age)) begin
			rec_b_q <= rd_q;
		end
	end

	// scan indexes for reverse and sort
	always_ff @(posedge clk) begin
		if (cmd.init_rev) begin
			i_q <= '0;
			j_q <= cnt_w - OW'(1);
		end else if (cmd.init_sort) begin
			i_q <= '0;
			n_q <= (sc_w > cnt_w) ? cnt_w : sc_w;
		end else if (cmd.best_start) begin
			best_q <= i_q;
			j_q    <= i_q + OW'(1);
		end else if (cmd.scan_cmp) begin
			j_q <= j_q + OW'(1);
			if (rd_q.age > rec_b_q.age) begin
				best_q <= j_q;
			end
		end else if (cmd.rev_step) begin
			i_q <= i_q + OW'(1);
			j_q <= j_q - OW'(1);
		end else if (cmd.sort_next) begin
			i_q <= i_q + OW'(1);
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q.status  <= status_q;
			rsp_q.out_id  <= show_q ? rec_a_q.id : 16'd0;
			rsp_q.out_age <= show_q ? rec_a_q.age : 8'd0;
			rsp_q.fill    <= 5'(count_q);
		end
	end

	assign rsp = rsp_q;

	// status toward the controller
	always_comb begin
		stat.op         = req_q.op;
		stat.full       = (count_q == CW'(DEPTH));
		stat.empty      = (count_q == '0);
		stat.ridx_ok    = (ridx_w < cnt_w);
		stat.rev_ok     = (cnt_w >= OW'(2));
		stat.rev_more   = (i_q < j_q);
		stat.sort_more  = (i_q < n_q);
		stat.scan_more  = (j_q < cnt_w);
		stat.best_moved = (best_q != i_q);
	end

endmodule

// ----- rtl/rqps_ctrl.sv -----
// controller state machine of the record queue: sequences each operation and the response handshake
module rqps_ctrl import rqps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [14:0] {
		S_IDLE      = 15'h0001,
		S_DISPATCH  = 15'h0002,
		S_FETCH     = 15'h0004,
		S_REV_CHK   = 15'h0008,
		S_REV_RDB   = 15'h0010,
		S_REV_CAP   = 15'h0020,
		S_REV_WRA   = 15'h0040,
		S_REV_WRB   = 15'h0080,
		S_SORT_ROW  = 15'h0100,
		S_SORT_HEAD = 15'h0200,
		S_SORT_SCAN = 15'h0400,
		S_SORT_CMP  = 15'h0800,
		S_SORT_SWAP = 15'h1000,
		S_SORT_SWB  = 15'h2000,
		S_DONE      = 15'h4000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				unique case (stat.op)
					OP_PUSH: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.mem_we      = 1'b1;
							cmd.off_sel     = OFF_COUNT;
							cmd.wd_sel      = WD_IN;
							cmd.push_commit = 1'b1;
						end
					end
					OP_POP: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.mem_re  = 1'b1;
							cmd.off_sel = OFF_ZERO;
							state_d     = S_FETCH;
						end
					end
					OP_READ: begin
						if (!stat.ridx_ok) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.mem_re  = 1'b1;
							cmd.off_sel = OFF_RIDX;
							state_d     = S_FETCH;
						end
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
					end
					OP_REVERSE: begin
						if (stat.rev_ok) begin
							cmd.init_rev = 1'b1;
							state_d      = S_REV_CHK;
						end
					end
					OP_SORT: begin
						cmd.init_sort = 1'b1;
						state_d       = S_SORT_ROW;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			// popped or read record arrives from the store
			S_FETCH: begin
				cmd.load_a     = 1'b1;
				cmd.show_rec   = 1'b1;
				cmd.pop_commit = (stat.op == OP_POP);
				state_d        = S_DONE;
			end
			// reverse: swap records at offsets i and j while i is below j
			S_REV_CHK: begin
				if (stat.rev_more) begin
					cmd.mem_re  = 1'b1;
					cmd.off_sel = OFF_I;
					state_d     = S_REV_RDB;
				end else begin
					state_d = S_DONE;
				end
			end
			S_REV_RDB: begin
				cmd.load_a  = 1'b1;
				cmd.mem_re  = 1'b1;
				cmd.off_sel = OFF_J;
				state_d     = S_REV_CAP;
			end
			S_REV_CAP: begin
				cmd.load_b = 1'b1;
				state_d    = S_REV_WRA;
			end
			S_REV_WRA: begin
				cmd.mem_we  = 1'b1;
				cmd.off_sel = OFF_I;
				cmd.wd_sel  = WD_B;
				state_d     = S_REV_WRB;
			end
			S_REV_WRB: begin
				cmd.mem_we   = 1'b1;
				cmd.off_sel  = OFF_J;
				cmd.wd_sel   = WD_A;
				cmd.rev_step = 1'b1;
				state_d      = S_REV_CHK;
			end
			// sort: one row per leading position, for the first min(sort_count, fill) positions
			S_SORT_ROW: begin
				if (stat.sort_more) begin
					cmd.mem_re  = 1'b1;
					cmd.off_sel = OFF_I;
					state_d     = S_SORT_HEAD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SORT_HEAD: begin
				cmd.load_a     = 1'b1;
				cmd.load_b     = 1'b1;
				cmd.best_start = 1'b1;
				state_d        = S_SORT_SCAN;
			end
			S_SORT_SCAN: begin
				if (stat.scan_more) begin
					cmd.mem_re  = 1'b1;
					cmd.off_sel = OFF_J;
					state_d     = S_SORT_CMP;
				end else begin
					state_d = S_SORT_SWAP;
				end
			end
			S_SORT_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = S_SORT_SCAN;
			end
			S_SORT_SWAP: begin
				if (stat.best_moved) begin
					cmd.mem_we  = 1'b1;
					cmd.off_sel = OFF_I;
					cmd.wd_sel  = WD_B;
					state_d     = S_SORT_SWB;
				end else begin
					cmd.sort_next = 1'b1;
					state_d       = S_SORT_ROW;
				end
			end
			S_SORT_SWB: begin
				cmd.mem_we    = 1'b1;
				cmd.off_sel   = OFF_BEST;
				cmd.wd_sel    = WD_A;
				cmd.sort_next = 1'b1;
				state_d       = S_SORT_ROW;
			end
			// hand the result to the output register once it is free
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule
